@@ rtl/aarm_pkg.sv @@
// Shared constants, types and tables for the axis-angle to rotation matrix block.
// Used by the stream interfaces, the CORDIC pipeline and the top level; no dependencies.
package aarm_pkg;

	// Field and number formats.
	localparam int FIELD_W      = 16;            // width of every port field
	localparam int FRAC_BITS    = 14;            // fraction bits of axis and matrix entries
	localparam int ANGLE_BITS   = 16;            // used bits of the binary angle
	localparam int TURN_W       = 32;            // internal binary angle, one turn = 2^TURN_W
	localparam int TRIG_FRAC    = 30;            // cos and sin are Q2.30
	localparam int CORDIC_STEPS = 30;            // micro-rotations, one pipeline stage each
	localparam int XY_W         = 32;            // CORDIC x and y
	localparam int Z_W          = TURN_W;        // CORDIC residual angle
	localparam int X_INIT       = 652032874;     // round(K * 2^30)

	// Datapath widths of the matrix arithmetic.
	localparam int SQ_W   = 2 * FIELD_W;             // u_i * u_j
	localparam int OMC_W  = XY_W + 1;                // 2^30 - cos
	localparam int PROD_W = SQ_W + OMC_W;            // u_i * u_j * (2^30 - cos)
	localparam int TERM_W = PROD_W - FRAC_BITS;      // that product after the floor shift
	localparam int DIAG_W = XY_W + FRAC_BITS;        // cos * 2^FRAC_BITS
	localparam int SKEW_W = FIELD_W + XY_W;          // u_i * sin
	localparam int ACC_W  = PROD_W + 1;              // holds the sum of any three terms

	localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (TRIG_FRAC - 1);
	localparam logic signed [ACC_W-1:0] ONE_POS    = ACC_W'(1) << FRAC_BITS;
	localparam logic signed [ACC_W-1:0] ONE_NEG    = -ONE_POS;

	// Axis as it travels beside the angle pipeline.
	typedef struct packed {
		logic signed [FIELD_W-1:0] x;
		logic signed [FIELD_W-1:0] y;
		logic signed [FIELD_W-1:0] z;
	} axis_t;

	// Nine matrix entries, named by row and column.
	typedef struct packed {
		logic [FIELD_W-1:0] r0_c0;
		logic [FIELD_W-1:0] r1_c0;
		logic [FIELD_W-1:0] r2_c0;
		logic [FIELD_W-1:0] r0_c1;
		logic [FIELD_W-1:0] r1_c1;
		logic [FIELD_W-1:0] r2_c1;
		logic [FIELD_W-1:0] r0_c2;
		logic [FIELD_W-1:0] r1_c2;
		logic [FIELD_W-1:0] r2_c2;
	} matrix_t;

	// Arctangent of 2^-i as a 32-bit binary angle, rounded.
	function automatic logic [TURN_W-1:0] atan_lut(input int unsigned idx);
		logic [TURN_W-1:0] v;
		case (idx)
			0:       v = 32'h2000_0000;
			1:       v = 32'h12E4_051E;
			2:       v = 32'h09FB_385B;
			3:       v = 32'h0511_11D4;
			4:       v = 32'h028B_0D43;
			5:       v = 32'h0145_D7E1;
			6:       v = 32'h00A2_F61E;
			7:       v = 32'h0051_7C55;
			8:       v = 32'h0028_BE53;
			9:       v = 32'h0014_5F2F;
			10:      v = 32'h000A_2F98;
			11:      v = 32'h0005_17CC;
			12:      v = 32'h0002_8BE6;
			13:      v = 32'h0001_45F3;
			14:      v = 32'h0000_A2F9;
			15:      v = 32'h0000_517D;
			16:      v = 32'h0000_28BE;
			17:      v = 32'h0000_145F;
			18:      v = 32'h0000_0A30;
			19:      v = 32'h0000_0518;
			20:      v = 32'h0000_028C;
			21:      v = 32'h0000_0146;
			22:      v = 32'h0000_00A3;
			23:      v = 32'h0000_0051;
			24:      v = 32'h0000_0029;
			25:      v = 32'h0000_0014;
			26:      v = 32'h0000_000A;
			27:      v = 32'h0000_0005;
			28:      v = 32'h0000_0003;
			29:      v = 32'h0000_0001;
			default: v = '0;
		endcase
		return v;
	endfunction

	// Round a Q(FRAC_BITS+30) sum to Q(FRAC_BITS) and clamp it to plus or minus one.
	function automatic logic [FIELD_W-1:0] round_sat(input logic signed [ACC_W-1:0] a);
		logic signed [ACC_W-1:0] r;
		logic signed [ACC_W-1:0] c;
		r = (a + ROUND_HALF) >>> TRIG_FRAC;
		if (r > ONE_POS) begin
			c = ONE_POS;
		end else if (r < ONE_NEG) begin
			c = ONE_NEG;
		end else begin
			c = r;
		end
		return c[FIELD_W-1:0];
	endfunction

endpackage

@@ rtl/aarm_in_if.sv @@
// Input channel: one axis-angle item per beat, valid/ready handshake.
// Depends on aarm_pkg for the field width.
interface aarm_in_if import aarm_pkg::*;;
	logic                      valid;
	logic                      ready;
	logic signed [FIELD_W-1:0] axis_x;
	logic signed [FIELD_W-1:0] axis_y;
	logic signed [FIELD_W-1:0] axis_z;
	logic [FIELD_W-1:0]        angle;

	modport source (output valid, output axis_x, output axis_y, output axis_z,
		output angle, input ready);
	modport sink (input valid, input axis_x, input axis_y, input axis_z,
		input angle, output ready);
endinterface

@@ rtl/aarm_out_if.sv @@
// Output channel: one 3x3 rotation matrix per beat, column-major fields.
// Depends on aarm_pkg for the field width.
interface aarm_out_if import aarm_pkg::*;;
	logic                      valid;
	logic                      ready;
	logic signed [FIELD_W-1:0] m_r0_c0;
	logic signed [FIELD_W-1:0] m_r1_c0;
	logic signed [FIELD_W-1:0] m_r2_c0;
	logic signed [FIELD_W-1:0] m_r0_c1;
	logic signed [FIELD_W-1:0] m_r1_c1;
	logic signed [FIELD_W-1:0] m_r2_c1;
	logic signed [FIELD_W-1:0] m_r0_c2;
	logic signed [FIELD_W-1:0] m_r1_c2;
	logic signed [FIELD_W-1:0] m_r2_c2;

	modport source (output valid, output m_r0_c0, output m_r1_c0, output m_r2_c0,
		output m_r0_c1, output m_r1_c1, output m_r2_c1, output m_r0_c2,
		output m_r1_c2, output m_r2_c2, input ready);
	modport sink (input valid, input m_r0_c0, input m_r1_c0, input m_r2_c0,
		input m_r0_c1, input m_r1_c1, input m_r2_c1, input m_r0_c2,
		input m_r1_c2, input m_r2_c2, output ready);
endinterface

@@ rtl/aarm_cordic.sv @@
// Pipelined rotation-mode CORDIC: quadrant fold stage, then one stage per micro-rotation.
// Carries the axis alongside the angle. Depends on aarm_pkg.
module aarm_cordic import aarm_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic [FIELD_W-1:0]       in_angle,
	input  axis_t                    in_axis,
	output logic                     out_valid,
	output logic signed [XY_W-1:0]   out_cos,
	output logic signed [XY_W-1:0]   out_sin,
	output axis_t                    out_axis
);

	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;
	localparam logic [1:0] QUAD_3 = 2'd3;

	// Stage 0 is the fold; stage i+1 holds the result of micro-rotation i.
	logic                   v_s    [CORDIC_STEPS+1];
	logic signed [XY_W-1:0] x_s    [CORDIC_STEPS+1];
	logic signed [XY_W-1:0] y_s    [CORDIC_STEPS+1];
	logic signed [Z_W-1:0]  z_s    [CORDIC_STEPS+1];
	logic [1:0]             quad_s [CORDIC_STEPS+1];
	axis_t                  axis_s [CORDIC_STEPS+1];

	logic [TURN_W-1:0] turn_a;
	logic [TURN_W-1:0] turn_h;
	logic [1:0]        quad;
	logic [TURN_W-1:0] resid;

	// Quadrant fold: leaves a residual angle within an eighth of a turn.
	always_comb begin
		turn_a = TURN_W'(in_angle[ANGLE_BITS-1:0]) << (TURN_W - ANGLE_BITS);
		turn_h = turn_a + (TURN_W'(1) << (TURN_W - 3));
		quad   = turn_h[TURN_W-1 -: 2];
		resid  = turn_a - {quad, (TURN_W-2)'(0)};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= XY_W'(X_INIT);
			y_s[0]    <= '0;
			z_s[0]    <= resid;
			quad_s[0] <= quad;
			axis_s[0] <= in_axis;
		end
	end

	// One micro-rotation per stage; the direction follows the residual's sign.
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		logic signed [XY_W-1:0] dx;
		logic signed [XY_W-1:0] dy;
		logic [TURN_W-1:0]      at;

		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;
		assign at = atan_lut(i);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_s[i][Z_W-1]) begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					z_s[i+1] <= z_s[i] - at;
				end else begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					z_s[i+1] <= z_s[i] + at;
				end
				quad_s[i+1] <= quad_s[i];
				axis_s[i+1] <= axis_s[i];
			end
		end
	end

	// Undo the fold on the last stage's output.
	always_comb begin
		case (quad_s[CORDIC_STEPS])
			QUAD_0: begin
				out_cos = x_s[CORDIC_STEPS];
				out_sin = y_s[CORDIC_STEPS];
			end
			QUAD_1: begin
				out_cos = -y_s[CORDIC_STEPS];
				out_sin = x_s[CORDIC_STEPS];
			end
			QUAD_2: begin
				out_cos = -x_s[CORDIC_STEPS];
				out_sin = -y_s[CORDIC_STEPS];
			end
			QUAD_3: begin
				out_cos = y_s[CORDIC_STEPS];
				out_sin = -x_s[CORDIC_STEPS];
			end
			default: begin
				out_cos = x_s[CORDIC_STEPS];
				out_sin = y_s[CORDIC_STEPS];
			end
		endcase
	end

	assign out_valid = v_s[CORDIC_STEPS];
	assign out_axis  = axis_s[CORDIC_STEPS];

endmodule

@@ rtl/axis_angle_to_rotation_matrix.sv @@
// Axis-angle to 3x3 rotation matrix (Rodrigues formula), fully pipelined.
// Throughput: one item per cycle while no stall is in effect. An accepted item passes
// 1 fold stage, 30 CORDIC stages, 3 multiply/sum stages and the output register, which drives out.valid.
// A one-entry skid buffer behind the output register keeps ready registered; a stall
// freezes the whole pipeline. Reset clears all valid bits; payload registers are not reset.
// Depends on aarm_pkg, aarm_in_if, aarm_out_if and aarm_cordic.
module axis_angle_to_rotation_matrix import aarm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	aarm_in_if.sink    axis_angle,
	aarm_out_if.source rot
);

	logic en;

	logic                   cv;
	logic signed [XY_W-1:0] ccos;
	logic signed [XY_W-1:0] csin;
	axis_t                  cax;

	// Stage 1: squares and cross products of the axis, sin products, 1 - cos and cos.
	logic                     v_s1;
	logic signed [SQ_W-1:0]   xx_s1, yy_s1, zz_s1, xy_s1, xz_s1, yz_s1;
	logic signed [OMC_W-1:0]  omc_s1;
	logic signed [XY_W-1:0]   cos_s1;
	logic signed [SKEW_W-1:0] sx_s1, sy_s1, sz_s1;

	// Stage 2: symmetric terms scaled by 1 - cos, cos * 2^FRAC_BITS and the sin products.
	logic                     v_s2;
	logic signed [TERM_W-1:0] txx_s2, tyy_s2, tzz_s2, txy_s2, txz_s2, tyz_s2;
	logic signed [DIAG_W-1:0] cd_s2;
	logic signed [SKEW_W-1:0] sx_s2, sy_s2, sz_s2;

	// Stage 3: the nine sums in column-major order.
	logic                    v_s3;
	logic signed [ACC_W-1:0] acc_s3 [9];

	logic signed [PROD_W-1:0] pxx, pyy, pzz, pxy, pxz, pyz;
	logic signed [ACC_W-1:0]  exx, eyy, ezz, exy, exz, eyz, ecd, esx, esy, esz;

	matrix_t res;
	matrix_t out_q;
	matrix_t skid_q;
	logic    out_v_q;
	logic    skid_v_q;

	// The pipeline moves whenever the skid buffer is empty.
	assign en               = !skid_v_q;
	assign axis_angle.ready = en;

	aarm_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (axis_angle.valid),
		.in_angle  (axis_angle.angle),
		.in_axis   ('{x: axis_angle.axis_x, y: axis_angle.axis_y, z: axis_angle.axis_z}),
		.out_valid (cv),
		.out_cos   (ccos),
		.out_sin   (csin),
		.out_axis  (cax)
	);

	// Valid bits of the multiply and sum stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= cv;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Products of stage 2, each 32 by 33 bits.
	assign pxx = xx_s1 * omc_s1;
	assign pyy = yy_s1 * omc_s1;
	assign pzz = zz_s1 * omc_s1;
	assign pxy = xy_s1 * omc_s1;
	assign pxz = xz_s1 * omc_s1;
	assign pyz = yz_s1 * omc_s1;

	// Sign-extended operands of the sums.
	assign exx = ACC_W'(txx_s2);
	assign eyy = ACC_W'(tyy_s2);
	assign ezz = ACC_W'(tzz_s2);
	assign exy = ACC_W'(txy_s2);
	assign exz = ACC_W'(txz_s2);
	assign eyz = ACC_W'(tyz_s2);
	assign ecd = ACC_W'(cd_s2);
	assign esx = ACC_W'(sx_s2);
	assign esy = ACC_W'(sy_s2);
	assign esz = ACC_W'(sz_s2);

	// Multiply and sum stages.
	always_ff @(posedge clk) begin
		if (en) begin
			xx_s1  <= cax.x * cax.x;
			yy_s1  <= cax.y * cax.y;
			zz_s1  <= cax.z * cax.z;
			xy_s1  <= cax.x * cax.y;
			xz_s1  <= cax.x * cax.z;
			yz_s1  <= cax.y * cax.z;
			omc_s1 <= (OMC_W'(1) <<< TRIG_FRAC) - OMC_W'(ccos);
			cos_s1 <= ccos;
			sx_s1  <= cax.x * csin;
			sy_s1  <= cax.y * csin;
			sz_s1  <= cax.z * csin;

			txx_s2 <= pxx[PROD_W-1:FRAC_BITS];
			tyy_s2 <= pyy[PROD_W-1:FRAC_BITS];
			tzz_s2 <= pzz[PROD_W-1:FRAC_BITS];
			txy_s2 <= pxy[PROD_W-1:FRAC_BITS];
			txz_s2 <= pxz[PROD_W-1:FRAC_BITS];
			tyz_s2 <= pyz[PROD_W-1:FRAC_BITS];
			cd_s2  <= DIAG_W'(cos_s1) <<< FRAC_BITS;
			sx_s2  <= sx_s1;
			sy_s2  <= sy_s1;
			sz_s2  <= sz_s1;

			acc_s3[0] <= exx + ecd;
			acc_s3[1] <= exy + esz;
			acc_s3[2] <= exz - esy;
			acc_s3[3] <= exy - esz;
			acc_s3[4] <= eyy + ecd;
			acc_s3[5] <= eyz + esx;
			acc_s3[6] <= exz + esy;
			acc_s3[7] <= eyz - esx;
			acc_s3[8] <= ezz + ecd;
		end
	end

	// Round and clamp each entry.
	always_comb begin
		res.r0_c0 = round_sat(acc_s3[0]);
		res.r1_c0 = round_sat(acc_s3[1]);
		res.r2_c0 = round_sat(acc_s3[2]);
		res.r0_c1 = round_sat(acc_s3[3]);
		res.r1_c1 = round_sat(acc_s3[4]);
		res.r2_c1 = round_sat(acc_s3[5]);
		res.r0_c2 = round_sat(acc_s3[6]);
		res.r1_c2 = round_sat(acc_s3[7]);
		res.r2_c2 = round_sat(acc_s3[8]);
	end

	// Output register and skid buffer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || rot.ready) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= v_s3;
			end
		end else if (en && v_s3) begin
			skid_v_q <= 1'b1;
		end
	end

	// Output register and skid buffer data.
	always_ff @(posedge clk) begin
		if (!out_v_q || rot.ready) begin
			out_q <= skid_v_q ? skid_q : res;
		end else if (en) begin
			skid_q <= res;
		end
	end

	assign rot.valid   = out_v_q;
	assign rot.m_r0_c0 = out_q.r0_c0;
	assign rot.m_r1_c0 = out_q.r1_c0;
	assign rot.m_r2_c0 = out_q.r2_c0;
	assign rot.m_r0_c1 = out_q.r0_c1;
	assign rot.m_r1_c1 = out_q.r1_c1;
	assign rot.m_r2_c1 = out_q.r2_c1;
	assign rot.m_r0_c2 = out_q.r0_c2;
	assign rot.m_r1_c2 = out_q.r1_c2;
	assign rot.m_r2_c2 = out_q.r2_c2;

endmodule

@@ sim/tb_axis_angle_to_rotation_matrix.sv @@
// Testbench for axis_angle_to_rotation_matrix: drives axis-angle beats, predicts each
// rotation matrix with its own CORDIC and Rodrigues arithmetic, and checks every output beat.
// Depends on aarm_pkg, aarm_in_if, aarm_out_if and the block under test.
`timescale 1ns / 100ps

module tb_axis_angle_to_rotation_matrix import aarm_pkg::*;;

	localparam int      CYCLE_LIMIT   = 400000;
	localparam int      SETTLE_CYCLES = 40;      // pipeline latency plus skid buffer
	localparam int      HOLD_CYCLES   = 300;
	localparam longint  CORDIC_X0     = 64'sd652032874;
	localparam longint  Q30_ONE       = 64'sd1 <<< 30;

	// Arctangent of 2^-i in units of 2^-32 turn.
	localparam longint ARCTAN_TURN [30] = '{
		64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
		64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
		64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517D, 64'h000028BE, 64'h0000145F,
		64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051,
		64'h00000029, 64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001
	};

	logic clk = 1'b0;
	logic arst_n;

	aarm_in_if  axis_angle_ch ();
	aarm_out_if rot_ch ();

	axis_angle_to_rotation_matrix DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.axis_angle (axis_angle_ch),
		.rot        (rot_ch)
	);

	matrix_t expected_matrices [$];
	int      send_idle_pct;
	int      recv_idle_pct;
	bit      hold_request;
	int      beats_sent;
	int      matrices_checked;
	int      mismatch_count;
	int      cycle_count;

	// Free-running clock, 10 ns period.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_axis_angle_to_rotation_matrix: FAIL");
			$finish;
		end
	end

	// Sine and cosine in Q2.30 from a quadrant fold and 30 CORDIC micro-rotations.
	function automatic void cordic_cos_sin(input logic [FIELD_W-1:0] ang,
		output longint cos_q30, output longint sin_q30);
		logic [31:0] turn;
		logic [31:0] quad;
		logic [31:0] resid;
		longint      x;
		longint      y;
		longint      z;
		longint      dx;
		longint      dy;
		int          i;
		turn  = 32'(ang[ANGLE_BITS-1:0]) << (32 - ANGLE_BITS);
		quad  = ((turn + 32'h2000_0000) >> 30) & 32'd3;
		resid = turn - (quad << 30);
		z = longint'($signed(resid));
		x = CORDIC_X0;
		y = 0;
		for (i = 0; i < 30; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - ARCTAN_TURN[i];
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + ARCTAN_TURN[i];
			end
		end
		case (quad)
			32'd0: begin cos_q30 = x;  sin_q30 = y;  end
			32'd1: begin cos_q30 = -y; sin_q30 = x;  end
			32'd2: begin cos_q30 = -x; sin_q30 = -y; end
			default: begin cos_q30 = y; sin_q30 = -x; end
		endcase
	endfunction

	// One matrix entry: outer-product term, diagonal cosine, skew times sine, then round and clamp.
	function automatic logic [FIELD_W-1:0] rodrigues_entry(input longint ui, input longint uj,
		input bit diag, input longint skew, input longint cos_q30, input longint sin_q30);
		longint acc;
		longint v;
		longint one;
		one = 64'sd1 <<< FRAC_BITS;
		acc = (ui * uj * (Q30_ONE - cos_q30)) >>> FRAC_BITS;
		if (diag) begin
			acc = acc + cos_q30 * one;
		end
		acc = acc + skew * sin_q30;
		v = (acc + (64'sd1 <<< 29)) >>> 30;
		if (v > one) begin
			v = one;
		end else if (v < -one) begin
			v = -one;
		end
		return v[FIELD_W-1:0];
	endfunction

	// Full rotation matrix for one axis-angle beat.
	function automatic matrix_t predict_matrix(input logic signed [FIELD_W-1:0] ax,
		input logic signed [FIELD_W-1:0] ay, input logic signed [FIELD_W-1:0] az,
		input logic [FIELD_W-1:0] ang);
		matrix_t m;
		longint  ux;
		longint  uy;
		longint  uz;
		longint  c;
		longint  s;
		ux = ax;
		uy = ay;
		uz = az;
		cordic_cos_sin(ang, c, s);
		m.r0_c0 = rodrigues_entry(ux, ux, 1'b1, 0,   c, s);
		m.r1_c0 = rodrigues_entry(uy, ux, 1'b0, uz,  c, s);
		m.r2_c0 = rodrigues_entry(uz, ux, 1'b0, -uy, c, s);
		m.r0_c1 = rodrigues_entry(ux, uy, 1'b0, -uz, c, s);
		m.r1_c1 = rodrigues_entry(uy, uy, 1'b1, 0,   c, s);
		m.r2_c1 = rodrigues_entry(uz, uy, 1'b0, ux,  c, s);
		m.r0_c2 = rodrigues_entry(ux, uz, 1'b0, uy,  c, s);
		m.r1_c2 = rodrigues_entry(uy, uz, 1'b0, -ux, c, s);
		m.r2_c2 = rodrigues_entry(uz, uz, 1'b1, 0,   c, s);
		return m;
	endfunction

	function automatic void check_entry(input string name, input logic [FIELD_W-1:0] exp_v,
		input logic [FIELD_W-1:0] got_v);
		if (exp_v !== got_v) begin
			$error("%s: expected %0d, actual %0d", name, $signed(exp_v), $signed(got_v));
			mismatch_count++;
		end
	endfunction

	// Receiver: random ready, or a long hold-off counted here when a test asks for one.
	initial begin
		int hold_left;
		hold_left = 0;
		rot_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				rot_ch.ready <= 1'b0;
				hold_left--;
			end else if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				rot_ch.ready <= 1'b0;
			end else begin
				rot_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Compare each accepted matrix beat with the oldest prediction.
	always @(posedge clk) begin
		matrix_t exp_m;
		if (arst_n && rot_ch.valid && rot_ch.ready) begin
			if (expected_matrices.size() == 0) begin
				$error("matrix beat arrived with no prediction waiting");
				mismatch_count++;
			end else begin
				exp_m = expected_matrices.pop_front();
				check_entry("m_r0_c0", exp_m.r0_c0, rot_ch.m_r0_c0);
				check_entry("m_r1_c0", exp_m.r1_c0, rot_ch.m_r1_c0);
				check_entry("m_r2_c0", exp_m.r2_c0, rot_ch.m_r2_c0);
				check_entry("m_r0_c1", exp_m.r0_c1, rot_ch.m_r0_c1);
				check_entry("m_r1_c1", exp_m.r1_c1, rot_ch.m_r1_c1);
				check_entry("m_r2_c1", exp_m.r2_c1, rot_ch.m_r2_c1);
				check_entry("m_r0_c2", exp_m.r0_c2, rot_ch.m_r0_c2);
				check_entry("m_r1_c2", exp_m.r1_c2, rot_ch.m_r1_c2);
				check_entry("m_r2_c2", exp_m.r2_c2, rot_ch.m_r2_c2);
				matrices_checked++;
			end
		end
	end

	// Offer one axis-angle beat, after a random gap, and hold it until accepted.
	// Valid stays high on return so back-to-back beats need no extra edge.
	task automatic send_axis_angle(input logic signed [FIELD_W-1:0] ax,
		input logic signed [FIELD_W-1:0] ay, input logic signed [FIELD_W-1:0] az,
		input logic [FIELD_W-1:0] ang);
		while ($urandom_range(99) < send_idle_pct) begin
			axis_angle_ch.valid <= 1'b0;
			@(posedge clk);
		end
		axis_angle_ch.valid  <= 1'b1;
		axis_angle_ch.axis_x <= ax;
		axis_angle_ch.axis_y <= ay;
		axis_angle_ch.axis_z <= az;
		axis_angle_ch.angle  <= ang;
		do begin
			@(posedge clk);
		end while (!axis_angle_ch.ready);
		expected_matrices.push_back(predict_matrix(ax, ay, az, ang));
		beats_sent++;
	endtask

	// Drop valid and wait until every predicted matrix has been checked.
	task automatic wait_all_matrices();
		axis_angle_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_matrices.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Mostly unit axes of random direction; some axis-aligned, some raw bit patterns.
	task automatic random_axis_angle(output logic signed [FIELD_W-1:0] ax,
		output logic signed [FIELD_W-1:0] ay, output logic signed [FIELD_W-1:0] az,
		output logic [FIELD_W-1:0] ang);
		real         fx;
		real         fy;
		real         fz;
		real         norm;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 15) begin
			ax = FIELD_W'($urandom);
			ay = FIELD_W'($urandom);
			az = FIELD_W'($urandom);
		end else if (pick < 30) begin
			ax = 0;
			ay = 0;
			az = 0;
			case ($urandom_range(2))
				0: ax = $urandom_range(1) ? 16384 : -16384;
				1: ay = $urandom_range(1) ? 16384 : -16384;
				default: az = $urandom_range(1) ? 16384 : -16384;
			endcase
		end else begin
			fx = real'($urandom_range(65535)) - 32767.5;
			fy = real'($urandom_range(65535)) - 32767.5;
			fz = real'($urandom_range(65535)) - 32767.5;
			norm = $sqrt(fx * fx + fy * fy + fz * fz);
			ax = FIELD_W'($rtoi(fx / norm * 16384.0));
			ay = FIELD_W'($rtoi(fy / norm * 16384.0));
			az = FIELD_W'($rtoi(fz / norm * 16384.0));
		end
		// Some angles sit right at the octant and quadrant fold boundaries.
		if ($urandom_range(99) < 20) begin
			ang = FIELD_W'($urandom_range(7) * 8192 + $urandom_range(6) - 3);
		end else begin
			ang = FIELD_W'($urandom);
		end
	endtask

	// Axis and angle corners, fold boundaries, saturating and degenerate axes.
	task automatic test_directed_corners();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_axis_angle(16384, 0, 0, 0);
		send_axis_angle(16384, 0, 0, 16384);
		send_axis_angle(0, 16384, 0, 32768);
		send_axis_angle(0, 0, 16384, 49152);
		send_axis_angle(0, 0, -16384, 8192);
		send_axis_angle(0, -16384, 0, 8191);
		send_axis_angle(-16384, 0, 0, 65535);
		send_axis_angle(9459, 9459, 9459, 24576);
		send_axis_angle(-32768, -32768, -32768, 16384);
		send_axis_angle(32767, 32767, 32767, 16'hAAAA);
		send_axis_angle(0, 0, 0, 16'h5555);
		send_axis_angle(0, 0, 0, 16'h8000);
		send_axis_angle(16384, 16384, 16384, 16'hFFFF);
		send_axis_angle(-1, -1, -1, 1);
		send_axis_angle(1, 1, 1, 16'h7FFF);
		send_axis_angle(11585, -11585, 0, 40960);
		send_axis_angle(0, 11585, 11585, 57344);
		send_axis_angle(-16384, -16384, 16384, 16'h2000);
		send_axis_angle(32767, -32768, 0, 16'hC000);
		send_axis_angle(21845, -21846, 0, 16'h1234);
		wait_all_matrices();
	endtask

	task automatic test_random_stream(input int count, input int send_pct, input int recv_pct);
		logic signed [FIELD_W-1:0] ax;
		logic signed [FIELD_W-1:0] ay;
		logic signed [FIELD_W-1:0] az;
		logic [FIELD_W-1:0]        ang;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		repeat (count) begin
			random_axis_angle(ax, ay, az, ang);
			send_axis_angle(ax, ay, az, ang);
		end
	endtask

	// The sender stops until the pipeline has emptied, then resumes.
	task automatic test_pause_until_drained();
		test_random_stream(12, 20, 20);
		wait_all_matrices();
		test_random_stream(12, 20, 20);
	endtask

	// The receiver holds off long enough for the pipeline and skid buffer to fill,
	// so the input side must stall while the sender keeps offering beats.
	task automatic test_output_backpressure();
		wait_all_matrices();
		hold_request = 1'b1;
		test_random_stream(70, 0, 0);
		wait_all_matrices();
	endtask

	// Reset once, then run the tests in turn.
	initial begin
		send_idle_pct    = 0;
		recv_idle_pct    = 0;
		hold_request     = 1'b0;
		beats_sent       = 0;
		matrices_checked = 0;
		mismatch_count   = 0;
		cycle_count      = 0;
		arst_n = 1'b0;
		axis_angle_ch.valid  <= 1'b0;
		axis_angle_ch.axis_x <= '0;
		axis_angle_ch.axis_y <= '0;
		axis_angle_ch.axis_z <= '0;
		axis_angle_ch.angle  <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_corners();
		test_random_stream(220, 36, 54);
		test_pause_until_drained();
		test_random_stream(220, 54, 36);
		test_output_backpressure();
		test_random_stream(220, 0, 0);

		wait_all_matrices();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Sent %0d axis-angle beats (corners, unit and raw axes, fold boundaries)",
			beats_sent);
		$display("Checked %0d matrices under random idling, a long output stall and a drain",
			matrices_checked);
		if (mismatch_count == 0 && expected_matrices.size() == 0) begin
			$display("tb_axis_angle_to_rotation_matrix: PASS");
		end else begin
			$display("tb_axis_angle_to_rotation_matrix: FAIL");
		end
		$finish;
	end

endmodule
